FILE: rtl/smavg_pkg.sv
`timescale 1ns / 1ps

package smavg_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int WINDOW_LENGTH = 10;
    localparam int CHANNELS      = 6;

    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW_LENGTH);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    // ceil(2^DIV_SHIFT / WINDOW_LENGTH): exact quotient for every window sum magnitude
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x_sample;
        logic signed [SAMPLE_W-1:0] accel_y_sample;
        logic signed [SAMPLE_W-1:0] accel_z_sample;
        logic signed [SAMPLE_W-1:0] gyro_x_sample;
        logic signed [SAMPLE_W-1:0] gyro_y_sample;
        logic signed [SAMPLE_W-1:0] gyro_z_sample;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x_average;
        logic signed [SAMPLE_W-1:0] accel_y_average;
        logic signed [SAMPLE_W-1:0] accel_z_average;
        logic signed [SAMPLE_W-1:0] gyro_x_average;
        logic signed [SAMPLE_W-1:0] gyro_y_average;
        logic signed [SAMPLE_W-1:0] gyro_z_average;
    } average_t;

    typedef struct packed {
        logic load_mul;
        logic load_out;
    } div_ctrl_t;

endpackage

FILE: rtl/smavg_lane.sv
`timescale 1ns / 1ps

module smavg_lane (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    input  logic signed [smavg_pkg::SAMPLE_W-1:0]   sample,
    output logic signed [smavg_pkg::SUM_W-1:0]      sum
);

    logic signed [smavg_pkg::SAMPLE_W-1:0] window_reg [smavg_pkg::WINDOW_LENGTH];
    logic signed [smavg_pkg::SUM_W-1:0]    sum_reg;
    logic signed [smavg_pkg::SUM_W-1:0]    sum_next;

    // add the newest sample, drop the oldest
    assign sum_next = sum_reg + smavg_pkg::SUM_W'(sample)
                    - smavg_pkg::SUM_W'(window_reg[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int k = 0; k < smavg_pkg::WINDOW_LENGTH; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else if (push)
        begin
            sum_reg <= sum_next;
            for (int k = 0; k < smavg_pkg::WINDOW_LENGTH - 1; k++)
            begin
                window_reg[k] <= window_reg[k + 1];
            end
            window_reg[smavg_pkg::WINDOW_LENGTH - 1] <= sample;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: rtl/smavg_div.sv
`timescale 1ns / 1ps

module smavg_div (
    input  logic                                    clk,
    input  smavg_pkg::div_ctrl_t                    ctrl,
    input  logic signed [smavg_pkg::SUM_W-1:0]      sum,
    output logic signed [smavg_pkg::SAMPLE_W-1:0]   quotient
);

    logic [smavg_pkg::SUM_W-1:0]           mag;
    logic [smavg_pkg::PROD_W-1:0]          prod_next;
    logic [smavg_pkg::PROD_W-1:0]          prod_reg;
    logic                                  neg_reg;
    logic [smavg_pkg::SAMPLE_W-1:0]        mag_quot;
    logic signed [smavg_pkg::SAMPLE_W-1:0] quotient_next;
    logic signed [smavg_pkg::SAMPLE_W-1:0] quotient_reg;

    assign mag       = sum[smavg_pkg::SUM_W-1] ? smavg_pkg::SUM_W'(-sum)
                                               : smavg_pkg::SUM_W'(sum);
    assign prod_next = smavg_pkg::PROD_W'(mag) * smavg_pkg::PROD_W'(smavg_pkg::RECIP);

    // truncate toward zero: divide the magnitude, then restore the sign
    assign mag_quot      = smavg_pkg::SAMPLE_W'(prod_reg >> smavg_pkg::DIV_SHIFT);
    assign quotient_next = neg_reg ? -$signed(mag_quot) : $signed(mag_quot);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            prod_reg <= prod_next;
            neg_reg  <= sum[smavg_pkg::SUM_W-1];
        end
        if (ctrl.load_out)
        begin
            quotient_reg <= quotient_next;
        end
    end

    assign quotient = quotient_reg;

endmodule

FILE: rtl/six_axis_moving_average_top.sv
`timescale 1ns / 1ps

// Ten-tap moving average over six motion-sensor channels.
// Input channel: sample_valid / sample_stall / sample. One transaction carries
// one signed 16-bit sample for each accelerometer and gyroscope axis.
// Output channel: average_valid / average_stall / average. One transaction
// carries the six window means, truncated toward zero.
// Each input transaction yields exactly one output transaction, in order.
// A sample accepted into the running sums passes the product register and then
// the output register before it is offered on the output.
// Throughput: one transaction per cycle unless the receiver stalls, set by the
// running-sum register of each lane, which absorbs one sample per clock.
// Reset clears all windows, running sums and valid flags; the first nine
// results average the new samples with zeros.
// When the receiver stalls, the output holds and the pipeline fills its
// empty stages; sample_stall rises only once every stage holds a result.
module six_axis_moving_average_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  smavg_pkg::sample_t  sample,
    output logic                average_valid,
    input  logic                average_stall,
    output smavg_pkg::average_t average
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic accept;
    logic load_s2;
    logic load_out;

    smavg_pkg::div_ctrl_t div_ctrl;

    logic signed [smavg_pkg::SAMPLE_W-1:0] chan_sample [smavg_pkg::CHANNELS];
    logic signed [smavg_pkg::SUM_W-1:0]    chan_sum    [smavg_pkg::CHANNELS];
    logic signed [smavg_pkg::SAMPLE_W-1:0] chan_avg    [smavg_pkg::CHANNELS];

    assign load_out     = s2_valid_reg && (!out_valid_reg || !average_stall);
    assign load_s2      = s1_valid_reg && (!s2_valid_reg || load_out);
    assign sample_stall = s1_valid_reg && !load_s2;
    assign accept       = sample_valid && !sample_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !load_s2);
    assign s2_valid_next  = load_s2 || (s2_valid_reg && !load_out);
    assign out_valid_next = load_out || (out_valid_reg && average_stall);

    assign div_ctrl.load_mul = load_s2;
    assign div_ctrl.load_out = load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign chan_sample[0] = sample.accel_x_sample;
    assign chan_sample[1] = sample.accel_y_sample;
    assign chan_sample[2] = sample.accel_z_sample;
    assign chan_sample[3] = sample.gyro_x_sample;
    assign chan_sample[4] = sample.gyro_y_sample;
    assign chan_sample[5] = sample.gyro_z_sample;

    for (genvar c = 0; c < smavg_pkg::CHANNELS; c++)
    begin : g_lane
        smavg_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .push   (accept),
            .sample (chan_sample[c]),
            .sum    (chan_sum[c])
        );

        smavg_div u_div (
            .clk      (clk),
            .ctrl     (div_ctrl),
            .sum      (chan_sum[c]),
            .quotient (chan_avg[c])
        );
    end

    // merge lane results into one transaction
    assign average.accel_x_average = chan_avg[0];
    assign average.accel_y_average = chan_avg[1];
    assign average.accel_z_average = chan_avg[2];
    assign average.gyro_x_average  = chan_avg[3];
    assign average.gyro_y_average  = chan_avg[4];
    assign average.gyro_z_average  = chan_avg[5];

    assign average_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && average_stall))
        else $error("input stalled while the pipeline has room");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction lost before the multiply stage");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !load_out) |=> s2_valid_reg)
        else $error("multiply stage dropped a held transaction");

    a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(average_valid) |-> $past(s2_valid_reg))
        else $error("output raised without a product ready");
`endif

endmodule
